@@ src/gaussian_kernel_sample_estimator_assert.svh @@
// Assertion macros shared by the estimator RTL.
`ifndef GAUSSIAN_KERNEL_SAMPLE_ESTIMATOR_ASSERT_SVH
`define GAUSSIAN_KERNEL_SAMPLE_ESTIMATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define GKSE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define GKSE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ src/gkse_pkg.sv @@
// Package with constants, codes and kernel tables of the estimator.
package gkse_pkg;
    localparam int MAX_SOURCES_DEF = 16384;
    localparam int DIMS_DEF = 9;
    localparam logic [1:0] KIND_SRC = 2'd0;
    localparam logic [1:0] KIND_TGT = 2'd1;
    localparam logic [1:0] KIND_SMP = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam logic [9:0] SPT_RESET = 10'd600;
    localparam logic [15:0] IBW_RESET = 16'd128;
    localparam logic [0:0] REG_SPT = 1'b0;
    localparam logic [0:0] REG_IBW = 1'b1;

    function automatic logic [16:0] expi(input logic [3:0] n);
        case (n)
            4'd0: expi = 17'd65536;
            4'd1: expi = 17'd24109;
            4'd2: expi = 17'd8869;
            4'd3: expi = 17'd3263;
            4'd4: expi = 17'd1200;
            4'd5: expi = 17'd442;
            4'd6: expi = 17'd162;
            4'd7: expi = 17'd60;
            4'd8: expi = 17'd22;
            4'd9: expi = 17'd8;
            4'd10: expi = 17'd3;
            4'd11: expi = 17'd1;
            default: expi = 17'd0;
        endcase
    endfunction

    function automatic logic [16:0] expf(input logic [3:0] f);
        case (f)
            4'd0: expf = 17'd65536;
            4'd1: expf = 17'd61565;
            4'd2: expf = 17'd57835;
            4'd3: expf = 17'd54331;
            4'd4: expf = 17'd51039;
            4'd5: expf = 17'd47947;
            4'd6: expf = 17'd45042;
            4'd7: expf = 17'd42313;
            4'd8: expf = 17'd39750;
            4'd9: expf = 17'd37341;
            4'd10: expf = 17'd35079;
            4'd11: expf = 17'd32954;
            4'd12: expf = 17'd30957;
            4'd13: expf = 17'd29081;
            4'd14: expf = 17'd27319;
            default: expf = 17'd25664;
        endcase
    endfunction
endpackage

@@ src/gkse_ram.sv @@
// Generic single-port synchronous RAM with registered read.
module gkse_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ src/gkse_div.sv @@
// Restoring divider for the rounded average of the kernel sum.
module gkse_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [26:0] dividend,
    input  logic [10:0] divisor,
    output logic        done,
    output logic [26:0] quotient
);
    logic [26:0] q_reg;
    logic [11:0] r_reg;
    logic [10:0] d_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [11:0] trial;

    assign trial = {r_reg[10:0], q_reg[26]};
    assign quotient = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg <= 5'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd26) begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_reg <= trial - {1'b0, d_reg};
                q_reg <= {q_reg[25:0], 1'b1};
            end else begin
                r_reg <= trial;
                q_reg <= {q_reg[25:0], 1'b0};
            end
        end
    end
endmodule

@@ src/gaussian_kernel_sample_estimator.sv @@
// Top level of the Gaussian kernel sum estimator.
// Channel   Direction  Ports       Content
// s_axis    in         s_t*        kind, source_index, coord_index, coord_value
// m_axis    out        m_t*        estimate
// apb       in         p*          samples_per_target, inv_bandwidth_sq
// A load beat is taken in the idle state; a sample beat makes one store
// read per coordinate from the single memory port, and the serial divider
// runs as well when an estimate completes. Reset is synchronous and
// clears control state and the accumulator; the source store has no reset.
// A stalled result beat waits in an output register while beats go on; only
// the next estimate stalls, in the accumulate step, until that beat is taken.
module gaussian_kernel_sample_estimator #(
    parameter int MAX_SOURCES = gkse_pkg::MAX_SOURCES_DEF,
    parameter int DIMS = gkse_pkg::DIMS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // source_index[13:0], coord_index[17:14], coord_value[33:18], zero fill [39:34]
    input  logic [39:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // estimate[16:0], zero fill [23:17]
    output logic [23:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int DEPTH = MAX_SOURCES * DIMS;
    localparam int AW = $clog2(DEPTH);
    localparam int SW = $clog2(MAX_SOURCES);
    localparam int DW = (DIMS > 1) ? $clog2(DIMS) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_KERN = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_MUL  = 3'd6;

    logic [2:0]  state_reg;
    logic [9:0]  spt_reg;
    logic [15:0] ibw_reg;
    logic [26:0] sum_reg;
    logic [9:0]  taken_reg;
    logic [15:0] tgt_reg [DIMS];
    logic [SW-1:0] src_reg;
    logic [4:0]  k_reg;
    logic        vld_reg;
    logic [4:0]  kd_reg;
    logic [35:0] norm_reg;
    logic [51:0] arg_reg;
    logic [16:0] kern_reg;
    logic [16:0] est_reg;
    logic        out_vld_reg;
    logic        div_start;
    logic        div_done;
    logic [26:0] div_q;
    logic [10:0] count;
    logic        est_due;

    logic [1:0]  kind;
    logic [13:0] sidx;
    logic [3:0]  cidx;
    logic [15:0] cval;
    logic        acc;
    logic        ram_we;
    logic [AW-1:0] ram_addr;
    logic [15:0] ram_rdata;
    logic signed [16:0] diff;
    logic [16:0] adiff;
    logic [33:0] sq;
    logic [33:0] prod;

    assign kind = s_tuser;
    assign sidx = s_tdata[13:0];
    assign cidx = s_tdata[17:14];
    assign cval = s_tdata[33:18];
    assign pready = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign acc = s_tvalid && s_tready;
    assign m_tvalid = out_vld_reg;
    assign m_tdata = {7'd0, est_reg};
    assign count = {1'b0, taken_reg} + 11'd1;
    assign est_due = (count >= {1'b0, spt_reg});

    always_comb begin
        prdata = '0;
        if (paddr[2] == gkse_pkg::REG_IBW) begin
            prdata = {16'd0, ibw_reg};
        end else begin
            prdata = {22'd0, spt_reg};
        end
    end

    always_comb begin
        ram_we = 1'b0;
        ram_addr = AW'(32'(src_reg) * DIMS + 32'(k_reg));
        if (acc) begin
            ram_addr = AW'(32'(sidx[SW-1:0]) * DIMS + 32'(cidx));
            if (kind == gkse_pkg::KIND_SRC && 32'(cidx) < DIMS
                    && 32'(sidx) < MAX_SOURCES) begin
                ram_we = 1'b1;
            end
        end
    end

    gkse_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_store (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(cval), .rdata(ram_rdata)
    );

    assign diff = $signed({ram_rdata[15], ram_rdata})
                - $signed({tgt_reg[kd_reg[DW-1:0]][15], tgt_reg[kd_reg[DW-1:0]]});
    assign adiff = diff[16] ? 17'(-diff) : 17'(diff);
    assign sq = 34'(adiff) * 34'(adiff);
    assign prod = 34'(gkse_pkg::expi(arg_reg[35:32])) * 34'(gkse_pkg::expf(arg_reg[31:28]));

    assign div_start = (state_reg == ST_ACC) && est_due && !out_vld_reg;

    gkse_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(sum_reg + 27'(kern_reg) + 27'(count >> 1)), .divisor(count),
        .done(div_done), .quotient(div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spt_reg <= gkse_pkg::SPT_RESET;
            ibw_reg <= gkse_pkg::IBW_RESET;
        end else if (psel && penable && pwrite && pready
                && paddr[2] == gkse_pkg::REG_SPT) begin
            spt_reg <= pwdata[9:0];
        end else if (psel && penable && pwrite && pready
                && paddr[2] == gkse_pkg::REG_IBW) begin
            ibw_reg <= pwdata[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (acc && kind == gkse_pkg::KIND_TGT && 32'(cidx) < DIMS) begin
            tgt_reg[cidx[DW-1:0]] <= cval;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sum_reg <= '0;
            taken_reg <= '0;
            vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            vld_reg <= 1'b0;
            if (out_vld_reg && m_tready) begin
                out_vld_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (acc && kind == gkse_pkg::KIND_SMP) begin
                        state_reg <= ST_READ;
                        src_reg <= sidx[SW-1:0];
                        k_reg <= '0;
                        norm_reg <= '0;
                    end
                end
                ST_READ: begin
                    if (32'(k_reg) < DIMS) begin
                        vld_reg <= 1'b1;
                        kd_reg <= k_reg;
                        k_reg <= k_reg + 5'd1;
                    end
                    if (vld_reg) begin
                        norm_reg <= norm_reg + 36'(sq);
                        if (32'(kd_reg) == DIMS - 1) begin
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    arg_reg <= 52'(norm_reg) * 52'(ibw_reg);
                    state_reg <= ST_KERN;
                end
                ST_KERN: begin
                    if (arg_reg[51:36] != 16'd0) begin
                        kern_reg <= '0;
                    end else begin
                        kern_reg <= 17'((prod + 34'd32768) >> 16);
                    end
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    if (div_start) begin
                        sum_reg <= sum_reg + 27'(kern_reg);
                        state_reg <= ST_DIV;
                    end else if (!est_due) begin
                        sum_reg <= sum_reg + 27'(kern_reg);
                        taken_reg <= count[9:0];
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        est_reg <= div_q[16:0];
                        sum_reg <= '0;
                        taken_reg <= '0;
                        out_vld_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `include "gaussian_kernel_sample_estimator_assert.svh"

    `GKSE_ASSERT_IMP(a_start_free, aclk, aresetn, div_start, !m_tvalid, "estimate over pending beat")
    `GKSE_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output dropped")
    `GKSE_ASSERT_IMP(a_est_range, aclk, aresetn, m_tvalid, est_reg <= 17'd65536, "estimate above one")
endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the Gaussian kernel sum estimator.
`timescale 1ns / 1ps

class estimate_scoreboard;
    logic [15:0] source_coords[int];
    logic [15:0] target_coords[9];
    logic [26:0] kernel_acc;
    logic [9:0]  sample_count;
    logic [9:0]  spt;
    logic [15:0] ibw;
    logic [16:0] pending_estimates[$];
    int mismatches;

    function new();
        kernel_acc = '0;
        sample_count = '0;
        spt = gkse_pkg::SPT_RESET;
        ibw = gkse_pkg::IBW_RESET;
        mismatches = 0;
    endfunction

    function void set_register(int idx, logic [31:0] value);
        if (idx == gkse_pkg::REG_SPT) begin
            spt = value[9:0];
        end else if (idx == gkse_pkg::REG_IBW) begin
            ibw = value[15:0];
        end
    endfunction

    function logic [16:0] kernel_value(logic [63:0] arg);
        logic [7:0] q44;
        logic [33:0] prod;
        if (arg >= (64'd16 << 32)) begin
            return '0;
        end
        q44 = arg[35:28];
        prod = gkse_pkg::expi(q44[7:4]) * gkse_pkg::expf(q44[3:0]) + 34'd32768;
        return prod[32:16];
    endfunction

    function void note_input(logic [1:0] kind, logic [13:0] sidx, logic [3:0] cidx,
                             logic [15:0] cval);
        logic [63:0] sq_norm;
        logic signed [17:0] d;
        logic [31:0] count, need;
        if (kind == gkse_pkg::KIND_SRC) begin
            if (cidx < 9) begin
                source_coords[sidx * 9 + cidx] = cval;
            end
        end else if (kind == gkse_pkg::KIND_TGT) begin
            if (cidx < 9) begin
                target_coords[cidx] = cval;
            end
        end else if (kind == gkse_pkg::KIND_SMP) begin
            sq_norm = '0;
            for (int k = 0; k < 9; k++) begin
                d = $signed(source_coords[sidx * 9 + k]) - $signed(target_coords[k]);
                if (d < 0) begin
                    d = -d;
                end
                sq_norm += 64'(d) * 64'(d);
            end
            kernel_acc += 27'(kernel_value(sq_norm * ibw));
            count = sample_count + 1;
            need = (spt == 0) ? 1 : spt;
            if (count >= need) begin
                pending_estimates.push_back(17'((32'(kernel_acc) + count / 2) / count));
                kernel_acc = '0;
                sample_count = '0;
            end else begin
                sample_count = count[9:0];
            end
        end
    endfunction

    function void check_result(logic [23:0] data);
        logic [16:0] want;
        if (pending_estimates.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected result beat: estimate %0d", data[16:0]);
            end
            return;
        end
        want = pending_estimates.pop_front();
        if (data !== {7'd0, want}) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("estimate mismatch: expected %0d, got %0d", want, data);
            end
        end
    endfunction
endclass

module tb;
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    estimate_scoreboard board;
    bit quiet_tail = 1'b0;
    int cycle_count = 0;
    int loaded_sources[$];

    gaussian_kernel_sample_estimator uut (.*);

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_result(m_tdata);
        end
    end

    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 12);
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_beat(logic [1:0] kind, logic [13:0] sidx, logic [3:0] cidx,
                             logic [15:0] cval);
        int gap;
        if (!quiet_tail && $urandom_range(0, 6) == 0) begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {6'd0, cval, cidx, sidx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_input(kind, sidx, cidx, cval);
        @(negedge aclk);
    endtask

    task automatic write_register(int idx, logic [31:0] value);
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (board.pending_estimates.size() != 0 && guard < 100000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (60) @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(idx * 4);
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        board.set_register(idx, value);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic load_source(int sidx, bit extreme);
        for (int k = 0; k < 9; k++) begin
            send_beat(gkse_pkg::KIND_SRC, 14'(sidx), 4'(k),
                      extreme ? (k[0] ? 16'h8000 : 16'h7FFF) : 16'($urandom_range(0, 8191) - 4096));
        end
        loaded_sources.push_back(sidx);
    endtask

    task automatic load_target(bit centered);
        for (int k = 0; k < 9; k++) begin
            send_beat(gkse_pkg::KIND_TGT, 14'($urandom), 4'(k),
                      centered ? 16'd0 : 16'($urandom_range(0, 8191) - 4096));
        end
    endtask

    task automatic sample_some(int n);
        for (int i = 0; i < n; i++) begin
            send_beat(gkse_pkg::KIND_SMP,
                      14'(loaded_sources[$urandom_range(0, loaded_sources.size() - 1)]),
                      4'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        int r;
        logic [1:0] rk;
        board = new();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_register(gkse_pkg::REG_SPT, 32'd1);
        write_register(gkse_pkg::REG_IBW, 32'd65535);
        for (int k = 0; k < 9; k++) begin
            send_beat(gkse_pkg::KIND_SRC, 14'd0, 4'(k), 16'd0);
        end
        loaded_sources.push_back(0);
        load_target(1'b1);
        sample_some(1);
        load_source(16383, 1'b1);
        send_beat(gkse_pkg::KIND_SMP, 14'd16383, 4'd0, 16'd0);
        send_beat(gkse_pkg::KIND_NONE, 14'h3FFF, 4'hF, 16'hFFFF);
        send_beat(gkse_pkg::KIND_SRC, 14'd0, 4'd15, 16'h1234);
        send_beat(gkse_pkg::KIND_TGT, 14'd0, 4'd9, 16'h4321);
        write_register(gkse_pkg::REG_IBW, 32'd1);
        sample_some(2);
        write_register(gkse_pkg::REG_SPT, 32'd0);
        sample_some(2);

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_register(gkse_pkg::REG_SPT, 32'd3);
                    write_register(gkse_pkg::REG_IBW, 32'd256);
                end
                1: write_register(gkse_pkg::REG_IBW, 32'd16);
                2: write_register(gkse_pkg::REG_SPT, 32'd1023);
                3: begin
                    write_register(gkse_pkg::REG_SPT, 32'd5);
                    write_register(gkse_pkg::REG_IBW, 32'($urandom_range(1, 65535)));
                end
                4: write_register(gkse_pkg::REG_SPT, 32'd2);
                default: write_register(gkse_pkg::REG_IBW, 32'd128);
            endcase
            if (phase == 5) begin
                quiet_tail = 1'b1;
            end
            load_target($urandom_range(0, 3) == 0);
            for (int i = 0; i < 3; i++) begin
                load_source($urandom_range(0, 16383), 1'b0);
            end
            for (int i = 0; i < 90; i++) begin
                r = $urandom_range(0, 19);
                if (r == 0) begin
                    rk = 2'($urandom);
                    if (rk == gkse_pkg::KIND_SMP) begin
                        sample_some(1);
                    end else begin
                        send_beat(rk, 14'($urandom), 4'($urandom), 16'($urandom));
                    end
                end else if (r == 1) begin
                    send_beat(gkse_pkg::KIND_TGT, 14'($urandom), 4'($urandom_range(0, 8)),
                              16'($urandom));
                end else begin
                    sample_some(1);
                end
            end
        end
        write_register(gkse_pkg::REG_SPT, 32'd20);
        sample_some(60);
        write_register(gkse_pkg::REG_SPT, 32'd1);

        r = 0;
        while (board.pending_estimates.size() != 0 && r < 200000) begin
            @(negedge aclk);
            r++;
        end
        repeat (100) @(negedge aclk);
        if (board.mismatches == 0 && board.pending_estimates.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
